[sv/afpi_pkg.sv]
`default_nettype none

package afpi_pkg;

    // table geometry
    localparam int MAX_ENTRIES = 64;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = 7;

    // field widths; a table word is angle, lift, drag, moment from the LSB up
    localparam int OP_W    = 2;
    localparam int ANGLE_W = 16;
    localparam int COEFF_W = 16;
    localparam int WORD_W  = ANGLE_W + 3 * COEFF_W;
    localparam int SLOPE_W = 20;

    // running sums of up to five lift / angle differences
    localparam int SUM_W = ANGLE_W + 4;
    localparam int MAG_W = SUM_W - 1;

    // shared restoring divider
    localparam int DIV_REM_W = MAG_W;
    localparam int DIV_SH_W  = SLOPE_W;
    localparam int DIV_CNT_W = $clog2(DIV_SH_W + 1);

    // sample interpolation: product, rounded dividend, quotient bits
    localparam int IP_PROD_W = ANGLE_W + COEFF_W;
    localparam int IP_NUM_W  = IP_PROD_W + 1;
    localparam int IP_Q_BITS = COEFF_W + 1;

    // slope scale: 23040 (1/128 deg to rad, Q12) times round(2^30 / pi)
    localparam int                 K_W    = 43;
    localparam int                 K_LO_W = 22;
    localparam logic [K_W-1:0]     SLOPE_K = K_W'(64'd23040 * 64'd341782638);
    localparam logic [K_LO_W-1:0]  K_LO    = SLOPE_K[K_LO_W-1:0];
    localparam logic [K_W-K_LO_W-1:0] K_HI = SLOPE_K[K_W-1:K_LO_W];
    localparam int                 ACC_W  = 64;
    localparam int                 FRAC_SH = 30;

    localparam logic [SLOPE_W-1:0] TWO_PI_Q12 = SLOPE_W'(25736);
    localparam logic [SLOPE_W-1:0] SLOPE_LIM  = SLOPE_W'(1) << (SLOPE_W - 1);
    localparam logic [SLOPE_W-1:0] SLOPE_MAX  = SLOPE_LIM - SLOPE_W'(1);

    typedef enum logic [OP_W-1:0] {
        OP_WRITE  = 2'd0,
        OP_SAMPLE = 2'd1,
        OP_SLOPE  = 2'd2
    } t_op;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SM_LO,
        ST_SM_HI,
        ST_SM_SCAN,
        ST_IP_MUL,
        ST_IP_DST,
        ST_IP_DIV,
        ST_IP_ACC,
        ST_SL_C0,
        ST_SL_CSCAN,
        ST_SL_W0,
        ST_SL_WSCAN,
        ST_SL_ABS,
        ST_SL_MLO,
        ST_SL_MHI,
        ST_SL_ADD,
        ST_SL_DST,
        ST_SL_DIV,
        ST_SL_FIN,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic                 start;
        logic [DIV_CNT_W-1:0] steps;
        logic [DIV_REM_W-1:0] divisor;
        logic [DIV_REM_W-1:0] rem_init;
        logic [DIV_SH_W-1:0]  low;
    } t_div_req;

    typedef struct packed {
        logic                done;
        logic [DIV_SH_W-1:0] quot;
    } t_div_rsp;

endpackage

`default_nettype wire

[sv/afpi_div.sv]
`default_nettype none

// Restoring divider, one quotient bit per cycle. The caller passes the
// upper dividend bits as rem_init (already below the divisor) and the
// remaining bits left aligned in low.
module afpi_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  afpi_pkg::t_div_req     i_req,
    output afpi_pkg::t_div_rsp     o_rsp
);
    import afpi_pkg::*;

    logic [DIV_REM_W-1:0] r_rem, n_rem;
    logic [DIV_SH_W-1:0]  r_sh, n_sh;
    logic [DIV_REM_W-1:0] r_dvs, n_dvs;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic                 r_busy, n_busy;
    logic                 r_done, n_done;

    // one trial subtraction per cycle
    always_comb begin
        logic [DIV_REM_W:0] cat;
        logic [DIV_REM_W:0] diff;
        logic               ge;
        cat    = {r_rem, r_sh[DIV_SH_W-1]};
        diff   = cat - {1'b0, r_dvs};
        ge     = (cat >= {1'b0, r_dvs});
        n_rem  = r_rem;
        n_sh   = r_sh;
        n_dvs  = r_dvs;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_req.start) begin
            n_rem  = i_req.rem_init;
            n_sh   = i_req.low;
            n_dvs  = i_req.divisor;
            n_cnt  = i_req.steps;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_rem = ge ? diff[DIV_REM_W-1:0] : cat[DIV_REM_W-1:0];
            n_sh  = {r_sh[DIV_SH_W-2:0], ge};
            n_cnt = r_cnt - DIV_CNT_W'(1);
            if (r_cnt == DIV_CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_sh  <= n_sh;
        r_dvs <= n_dvs;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_sh;

endmodule

`default_nettype wire

[sv/airfoil_polar_interpolator_unit.sv]
`default_nettype none

// Channel   Direction  Handshake               Payload
// input     in         i_valid / o_stall       i_operation, i_entry_*, i_query_angle
// result    out        o_valid / i_stall       o_lift/drag/moment_coeff, o_found,
//                                              o_slope_per_rad
// config    in         i_cfg_valid / o_cfg_ready  i_cfg_data (entry_count)
//
// One item at a time. A write item is written to the table as it is taken. A
// sample fetches the span ends, then does a linear scan of the table memory,
// one read a cycle, then per coefficient a multiply and a 17-step pass of the
// shared divider. A slope item does the zero-crossing scan, a window of up to
// six reads and a 20-step divide. Reset is synchronous, active low, and clears
// the control state and entry_count; table contents stay undefined until
// written. A finished result waits in the output register while the next
// item is taken.
module airfoil_polar_interpolator_unit (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    output wire logic                            o_stall,
    input  wire logic [afpi_pkg::OP_W-1:0]       i_operation,
    input  wire logic [afpi_pkg::IDX_W-1:0]      i_entry_index,
    input  wire logic signed [afpi_pkg::ANGLE_W-1:0] i_entry_angle,
    input  wire logic signed [afpi_pkg::COEFF_W-1:0] i_entry_lift,
    input  wire logic signed [afpi_pkg::COEFF_W-1:0] i_entry_drag,
    input  wire logic signed [afpi_pkg::COEFF_W-1:0] i_entry_moment,
    input  wire logic signed [afpi_pkg::ANGLE_W-1:0] i_query_angle,
    output wire logic                            o_valid,
    input  wire logic                            i_stall,
    output wire logic signed [afpi_pkg::COEFF_W-1:0] o_lift_coeff,
    output wire logic signed [afpi_pkg::COEFF_W-1:0] o_drag_coeff,
    output wire logic signed [afpi_pkg::COEFF_W-1:0] o_moment_coeff,
    output wire logic                            o_found,
    output wire logic signed [afpi_pkg::SLOPE_W-1:0] o_slope_per_rad,
    input  wire logic                            i_cfg_valid,
    output wire logic                            o_cfg_ready,
    input  wire logic [afpi_pkg::CNT_W-1:0]      i_cfg_data
);
    import afpi_pkg::*;

    localparam logic signed [COEFF_W+1:0] CMAX = (COEFF_W+2)'((1 << (COEFF_W - 1)) - 1);
    localparam logic signed [COEFF_W+1:0] CMIN = -CMAX - (COEFF_W+2)'(1);

    // polar table
    logic [WORD_W-1:0] mem [MAX_ENTRIES];
    logic [WORD_W-1:0] r_rd_data;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic              wr_en;

    // control and working registers
    t_state                      r_state, n_state;
    logic [CNT_W-1:0]            r_entry_count;
    logic signed [ANGLE_W-1:0]   r_q, n_q;
    logic [WORD_W-1:0]           r_prev, n_prev;
    logic [WORD_W-1:0]           r_cur, n_cur;
    logic [IDX_W-1:0]            r_idx, n_idx;
    logic [IDX_W-1:0]            r_last, n_last;
    logic [IDX_W-1:0]            r_end, n_end;
    logic [1:0]                  r_sel, n_sel;
    logic [ANGLE_W-1:0]          r_dq, n_dq;
    logic [ANGLE_W-1:0]          r_den, n_den;
    logic                        r_neg, n_neg;
    logic [IP_PROD_W-1:0]        r_prod, n_prod;
    logic signed [SUM_W-1:0]     r_snum, n_snum;
    logic signed [SUM_W-1:0]     r_sden, n_sden;
    logic                        r_used, n_used;
    logic [MAG_W-1:0]            r_nm, n_nm;
    logic [MAG_W-1:0]            r_dm, n_dm;
    logic [ACC_W-1:0]            r_acc, n_acc;
    logic [SLOPE_W-1:0]          r_qm, n_qm;

    // result being built
    logic [COEFF_W-1:0]          r_coef [3];
    logic [COEFF_W-1:0]          n_coef [3];
    logic                        r_found, n_found;
    logic [SLOPE_W-1:0]          r_slope, n_slope;

    // output register
    logic                        r_out_valid;
    logic                        out_load;
    logic [COEFF_W-1:0]          r_out_lift, r_out_drag, r_out_moment;
    logic                        r_out_found;
    logic [SLOPE_W-1:0]          r_out_slope;

    t_div_req                    div_req;
    t_div_rsp                    div_rsp;

    afpi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // sequencer: next state, memory addresses, datapath
    always_comb begin
        logic signed [ANGLE_W-1:0] a0;
        logic signed [ANGLE_W-1:0] a1;
        logic signed [ANGLE_W:0]   da;
        logic signed [ANGLE_W:0]   dq_s;
        logic signed [COEFF_W-1:0] y0;
        logic signed [COEFF_W-1:0] y1;
        logic signed [COEFF_W-1:0] l0;
        logic signed [COEFF_W-1:0] l1;
        logic signed [COEFF_W:0]   dy;
        logic signed [COEFF_W:0]   dl;
        logic [COEFF_W-1:0]        dy_mag;
        logic [CNT_W-1:0]          used;
        logic [IP_NUM_W-1:0]       num;
        logic [IP_Q_BITS-1:0]      qt;
        logic signed [COEFF_W+1:0] qs;
        logic signed [COEFF_W+1:0] v;
        logic [IDX_W-1:0]          ctr;
        logic [IDX_W:0]            wend;
        logic [SUM_W-1:0]          abs_n;
        logic [SUM_W-1:0]          abs_d;
        logic [IP_NUM_W-1:0]       ap;
        logic [SLOPE_W-1:0]        qm_c;

        a0     = r_prev[ANGLE_W-1:0];
        a1     = r_rd_data[ANGLE_W-1:0];
        da     = {a1[ANGLE_W-1], a1} - {a0[ANGLE_W-1], a0};
        dq_s   = {r_q[ANGLE_W-1], r_q} - {a0[ANGLE_W-1], a0};
        y0     = r_prev[ANGLE_W + r_sel * COEFF_W +: COEFF_W];
        y1     = r_cur[ANGLE_W + r_sel * COEFF_W +: COEFF_W];
        l0     = r_prev[ANGLE_W +: COEFF_W];
        l1     = r_rd_data[ANGLE_W +: COEFF_W];
        dy     = {y1[COEFF_W-1], y1} - {y0[COEFF_W-1], y0};
        dl     = {l1[COEFF_W-1], l1} - {l0[COEFF_W-1], l0};
        dy_mag = dy[COEFF_W] ? COEFF_W'(-dy) : dy[COEFF_W-1:0];
        used   = (r_entry_count > CNT_W'(MAX_ENTRIES)) ? CNT_W'(MAX_ENTRIES) : r_entry_count;
        num    = {1'b0, r_prod} + IP_NUM_W'(r_den >> 1);
        qt     = (r_den == '0) ? '0 : div_rsp.quot[IP_Q_BITS-1:0];
        qs     = $signed({1'b0, qt});
        v      = $signed({{2{y0[COEFF_W-1]}}, y0}) + (r_neg ? -qs : qs);
        ctr    = (r_rd_data[ANGLE_W-1] == 1'b0 && a0 <= 0) ? r_idx - IDX_W'(1) : '0;
        wend   = {1'b0, ctr} + (IDX_W+1)'(3);
        abs_n  = r_snum[SUM_W-1] ? SUM_W'(-r_snum) : SUM_W'(r_snum);
        abs_d  = r_sden[SUM_W-1] ? SUM_W'(-r_sden) : SUM_W'(r_sden);
        ap     = r_acc[FRAC_SH + IP_NUM_W - 1:FRAC_SH];
        qm_c   = (r_qm > SLOPE_LIM) ? SLOPE_LIM : r_qm;

        n_state = r_state;
        n_q     = r_q;
        n_prev  = r_prev;
        n_cur   = r_cur;
        n_idx   = r_idx;
        n_last  = r_last;
        n_end   = r_end;
        n_sel   = r_sel;
        n_dq    = r_dq;
        n_den   = r_den;
        n_neg   = r_neg;
        n_prod  = r_prod;
        n_snum  = r_snum;
        n_sden  = r_sden;
        n_used  = r_used;
        n_nm    = r_nm;
        n_dm    = r_dm;
        n_acc   = r_acc;
        n_qm    = r_qm;
        n_coef  = r_coef;
        n_found = r_found;
        n_slope = r_slope;
        rd_en   = 1'b0;
        rd_addr = r_idx + IDX_W'(1);
        wr_en   = 1'b0;
        out_load = 1'b0;
        div_req  = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_coef  = '{default: '0};
                    n_found = 1'b0;
                    n_slope = '0;
                    n_q     = i_query_angle;
                    n_last  = IDX_W'(used - CNT_W'(1));
                    unique case (t_op'(i_operation))
                        OP_WRITE: begin
                            wr_en = 1'b1;
                        end
                        OP_SAMPLE: begin
                            if (used < CNT_W'(2)) begin
                                n_state = ST_OUT;
                            end else begin
                                rd_en   = 1'b1;
                                rd_addr = '0;
                                n_state = ST_SM_LO;
                            end
                        end
                        OP_SLOPE: begin
                            n_slope = TWO_PI_Q12;
                            if (used < CNT_W'(3)) begin
                                n_state = ST_OUT;
                            end else begin
                                rd_en   = 1'b1;
                                rd_addr = '0;
                                n_state = ST_SL_C0;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            // sample: fetch the span ends, clamp, then scan for a bracket
            ST_SM_LO: begin
                n_prev  = r_rd_data;
                rd_en   = 1'b1;
                rd_addr = r_last;
                n_state = ST_SM_HI;
            end
            ST_SM_HI: begin
                if (r_q < a0) begin
                    n_q = a0;
                end else if (r_q > a1) begin
                    n_q = a1;
                end
                rd_en   = 1'b1;
                rd_addr = IDX_W'(1);
                n_idx   = IDX_W'(1);
                n_state = ST_SM_SCAN;
            end
            ST_SM_SCAN: begin
                if (r_q >= a0 && r_q <= a1) begin
                    n_cur   = r_rd_data;
                    n_found = 1'b1;
                    n_sel   = '0;
                    n_dq    = dq_s[ANGLE_W-1:0];
                    n_den   = da[ANGLE_W-1:0];
                    n_state = ST_IP_MUL;
                end else if (r_idx == r_last) begin
                    n_state = ST_OUT;
                end else begin
                    n_prev  = r_rd_data;
                    n_idx   = r_idx + IDX_W'(1);
                    rd_en   = 1'b1;
                    n_state = ST_SM_SCAN;
                end
            end

            // interpolate one coefficient per pass
            ST_IP_MUL: begin
                n_neg   = dy[COEFF_W];
                n_prod  = r_dq * dy_mag;
                n_state = (r_den == '0) ? ST_IP_ACC : ST_IP_DST;
            end
            ST_IP_DST: begin
                div_req.start    = 1'b1;
                div_req.steps    = DIV_CNT_W'(IP_Q_BITS);
                div_req.divisor  = DIV_REM_W'(r_den);
                div_req.rem_init = DIV_REM_W'(num[IP_NUM_W-1:IP_Q_BITS]);
                div_req.low      = DIV_SH_W'(num[IP_Q_BITS-1:0]) << (DIV_SH_W - IP_Q_BITS);
                n_state          = ST_IP_DIV;
            end
            ST_IP_DIV: begin
                if (div_rsp.done) begin
                    n_state = ST_IP_ACC;
                end
            end
            ST_IP_ACC: begin
                if (v > CMAX) begin
                    n_coef[r_sel] = CMAX[COEFF_W-1:0];
                end else if (v < CMIN) begin
                    n_coef[r_sel] = CMIN[COEFF_W-1:0];
                end else begin
                    n_coef[r_sel] = v[COEFF_W-1:0];
                end
                if (r_sel == 2'd2) begin
                    n_state = ST_OUT;
                end else begin
                    n_sel   = r_sel + 2'd1;
                    n_state = ST_IP_MUL;
                end
            end

            // slope: find the zero crossing segment
            ST_SL_C0: begin
                n_prev  = r_rd_data;
                rd_en   = 1'b1;
                rd_addr = IDX_W'(1);
                n_idx   = IDX_W'(1);
                n_state = ST_SL_CSCAN;
            end
            ST_SL_CSCAN: begin
                if ((a0 <= 0 && a1 >= 0) || r_idx == r_last) begin
                    // window of segments centre-2 .. centre+2 inside the table
                    n_idx   = (ctr >= IDX_W'(2)) ? ctr - IDX_W'(2) : '0;
                    n_end   = (wend > {1'b0, r_last}) ? r_last : wend[IDX_W-1:0];
                    rd_en   = 1'b1;
                    rd_addr = (ctr >= IDX_W'(2)) ? ctr - IDX_W'(2) : '0;
                    n_snum  = '0;
                    n_sden  = '0;
                    n_used  = 1'b0;
                    n_state = ST_SL_W0;
                end else begin
                    n_prev  = r_rd_data;
                    n_idx   = r_idx + IDX_W'(1);
                    rd_en   = 1'b1;
                end
            end
            ST_SL_W0: begin
                n_prev  = r_rd_data;
                n_idx   = r_idx + IDX_W'(1);
                rd_en   = 1'b1;
                n_state = ST_SL_WSCAN;
            end
            ST_SL_WSCAN: begin
                if (da != '0) begin
                    n_snum = r_snum + SUM_W'(dl);
                    n_sden = r_sden + SUM_W'(da);
                    n_used = 1'b1;
                end
                if (r_idx == r_end) begin
                    n_state = ST_SL_ABS;
                end else begin
                    n_prev = r_rd_data;
                    n_idx  = r_idx + IDX_W'(1);
                    rd_en  = 1'b1;
                end
            end

            // slope = round(N * K / (D * 2^30)), K split in two products
            ST_SL_ABS: begin
                if (!r_used || r_sden == '0) begin
                    n_state = ST_OUT;
                end else begin
                    n_nm    = abs_n[MAG_W-1:0];
                    n_dm    = abs_d[MAG_W-1:0];
                    n_neg   = r_snum[SUM_W-1] ^ r_sden[SUM_W-1];
                    n_state = ST_SL_MLO;
                end
            end
            ST_SL_MLO: begin
                n_acc   = ACC_W'(r_nm * K_LO);
                n_state = ST_SL_MHI;
            end
            ST_SL_MHI: begin
                n_acc   = r_acc + (ACC_W'(r_nm * K_HI) << K_LO_W);
                n_state = ST_SL_ADD;
            end
            ST_SL_ADD: begin
                // add half the divisor for rounding
                n_acc   = r_acc + (ACC_W'(r_dm) << (FRAC_SH - 1));
                n_state = ST_SL_DST;
            end
            ST_SL_DST: begin
                if (MAG_W'(ap[IP_NUM_W-1:DIV_SH_W]) >= r_dm) begin
                    n_qm    = SLOPE_LIM;
                    n_state = ST_SL_FIN;
                end else begin
                    div_req.start    = 1'b1;
                    div_req.steps    = DIV_CNT_W'(DIV_SH_W);
                    div_req.divisor  = r_dm;
                    div_req.rem_init = DIV_REM_W'(ap[IP_NUM_W-1:DIV_SH_W]);
                    div_req.low      = ap[DIV_SH_W-1:0];
                    n_state          = ST_SL_DIV;
                end
            end
            ST_SL_DIV: begin
                if (div_rsp.done) begin
                    n_qm    = div_rsp.quot;
                    n_state = ST_SL_FIN;
                end
            end
            ST_SL_FIN: begin
                if (r_neg) begin
                    n_slope = -qm_c;
                end else begin
                    n_slope = (qm_c == SLOPE_LIM) ? SLOPE_MAX : qm_c;
                end
                n_state = ST_OUT;
            end

            // hand the result to the output register once it is free
            ST_OUT: begin
                if (!r_out_valid || !i_stall) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // table memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[i_entry_index] <= {i_entry_moment, i_entry_drag, i_entry_lift, i_entry_angle};
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_out_valid   <= 1'b0;
            r_entry_count <= '0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                r_entry_count <= i_cfg_data;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_q     <= n_q;
        r_prev  <= n_prev;
        r_cur   <= n_cur;
        r_idx   <= n_idx;
        r_last  <= n_last;
        r_end   <= n_end;
        r_sel   <= n_sel;
        r_dq    <= n_dq;
        r_den   <= n_den;
        r_neg   <= n_neg;
        r_prod  <= n_prod;
        r_snum  <= n_snum;
        r_sden  <= n_sden;
        r_used  <= n_used;
        r_nm    <= n_nm;
        r_dm    <= n_dm;
        r_acc   <= n_acc;
        r_qm    <= n_qm;
        r_coef  <= n_coef;
        r_found <= n_found;
        r_slope <= n_slope;
        if (out_load) begin
            r_out_lift   <= r_coef[0];
            r_out_drag   <= r_coef[1];
            r_out_moment <= r_coef[2];
            r_out_found  <= r_found;
            r_out_slope  <= r_slope;
        end
    end

    assign o_stall         = (r_state != ST_IDLE);
    assign o_valid         = r_out_valid;
    assign o_lift_coeff    = r_out_lift;
    assign o_drag_coeff    = r_out_drag;
    assign o_moment_coeff  = r_out_moment;
    assign o_found         = r_out_found;
    assign o_slope_per_rad = r_out_slope;
    assign o_cfg_ready     = 1'b1;

endmodule

`default_nettype wire

[dv/airfoil_polar_interpolator_unit_test.sv]
`timescale 1ns / 1ps

module airfoil_polar_interpolator_unit_test;

    localparam int TABLE_DEPTH   = afpi_pkg::MAX_ENTRIES;
    localparam int ITEM_TARGET   = 1950;
    localparam int CYCLE_LIMIT   = 2_500_000;
    localparam int SETTLE_CYCLES = 200;
    localparam int CFG_SETTLE    = 16;
    localparam int REPORT_LIMIT  = 10;
    localparam int LONG_HOLD     = 400;

    // op code with no meaning to the block
    localparam logic [afpi_pkg::OP_W-1:0] OP_RESERVED = 2'd3;

    // slope scaling: 1/128 deg to rad in Q12, times 2^30 / pi
    localparam longint DEG128_TO_RAD_Q12 = 23040;
    localparam longint INV_PI_Q30        = 341782638;
    localparam longint TWO_PI_SLOPE      = 25736;
    localparam longint SLOPE_HI          = 524287;
    localparam longint COEFF_HI          = 32767;
    localparam longint COEFF_LO          = -32768;

    typedef struct {
        logic [afpi_pkg::OP_W-1:0]           op;
        logic [afpi_pkg::IDX_W-1:0]          index;
        logic signed [afpi_pkg::ANGLE_W-1:0] angle;
        logic signed [afpi_pkg::COEFF_W-1:0] lift;
        logic signed [afpi_pkg::COEFF_W-1:0] drag;
        logic signed [afpi_pkg::COEFF_W-1:0] moment;
        logic signed [afpi_pkg::ANGLE_W-1:0] query;
    } polar_item_t;

    typedef struct {
        logic signed [afpi_pkg::COEFF_W-1:0] lift;
        logic signed [afpi_pkg::COEFF_W-1:0] drag;
        logic signed [afpi_pkg::COEFF_W-1:0] moment;
        logic                                found;
        logic signed [afpi_pkg::SLOPE_W-1:0] slope;
    } polar_result_t;

    typedef enum {SHAPE_RAMP, SHAPE_WILD, SHAPE_NOISE} table_shape_t;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    wire  o_stall;
    logic [afpi_pkg::OP_W-1:0]           i_operation;
    logic [afpi_pkg::IDX_W-1:0]          i_entry_index;
    logic signed [afpi_pkg::ANGLE_W-1:0] i_entry_angle;
    logic signed [afpi_pkg::COEFF_W-1:0] i_entry_lift;
    logic signed [afpi_pkg::COEFF_W-1:0] i_entry_drag;
    logic signed [afpi_pkg::COEFF_W-1:0] i_entry_moment;
    logic signed [afpi_pkg::ANGLE_W-1:0] i_query_angle;
    wire  o_valid;
    logic i_stall;
    wire signed [afpi_pkg::COEFF_W-1:0]  o_lift_coeff;
    wire signed [afpi_pkg::COEFF_W-1:0]  o_drag_coeff;
    wire signed [afpi_pkg::COEFF_W-1:0]  o_moment_coeff;
    wire                                 o_found;
    wire signed [afpi_pkg::SLOPE_W-1:0]  o_slope_per_rad;
    logic i_cfg_valid;
    wire  o_cfg_ready;
    logic [afpi_pkg::CNT_W-1:0]          i_cfg_data;

    // polar table as the block should hold it
    logic signed [afpi_pkg::ANGLE_W-1:0] tbl_angle  [TABLE_DEPTH];
    logic signed [afpi_pkg::COEFF_W-1:0] tbl_lift   [TABLE_DEPTH];
    logic signed [afpi_pkg::COEFF_W-1:0] tbl_drag   [TABLE_DEPTH];
    logic signed [afpi_pkg::COEFF_W-1:0] tbl_moment [TABLE_DEPTH];
    logic [afpi_pkg::CNT_W-1:0]          tbl_count;

    polar_result_t results_due[$];
    int mismatch_count = 0;
    int items_sent     = 0;
    int long_hold_req  = 0;
    bit tx_idling      = 1'b1;
    bit rx_idling      = 1'b1;

    airfoil_polar_interpolator_unit uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_operation     (i_operation),
        .i_entry_index   (i_entry_index),
        .i_entry_angle   (i_entry_angle),
        .i_entry_lift    (i_entry_lift),
        .i_entry_drag    (i_entry_drag),
        .i_entry_moment  (i_entry_moment),
        .i_query_angle   (i_query_angle),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_lift_coeff    (o_lift_coeff),
        .o_drag_coeff    (o_drag_coeff),
        .o_moment_coeff  (o_moment_coeff),
        .o_found         (o_found),
        .o_slope_per_rad (o_slope_per_rad),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------
    // Table model
    // ---------------------------------------------------------------
    function automatic int active_entries();
        return (tbl_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(tbl_count);
    endfunction

    // nearest, ties away from zero
    function automatic longint round_half_away(longint num, longint den);
        longint mag_n, mag_d, q;
        mag_n = (num < 0) ? -num : num;
        mag_d = (den < 0) ? -den : den;
        q = (mag_n + mag_d / 2) / mag_d;
        return ((num < 0) != (den < 0)) ? -q : q;
    endfunction

    function automatic logic signed [15:0] interp_coeff(longint q, longint a0, longint a1,
                                                        longint y0, longint y1);
        longint v;
        v = y0;
        // zero-width segment keeps the left entry
        if (a1 != a0)
            v = y0 + round_half_away((q - a0) * (y1 - y0), a1 - a0);
        if (v > COEFF_HI)
            v = COEFF_HI;
        else if (v < COEFF_LO)
            v = COEFF_LO;
        return 16'(v);
    endfunction

    function automatic polar_result_t sample_polar(logic signed [15:0] query);
        polar_result_t r;
        int n;
        longint q, a0, a1;
        r = '{default: '0};
        n = active_entries();
        if (n < 2)
            return r;
        // clamp: the first entry wins when the span is inverted
        q = query;
        if (q < tbl_angle[0])
            q = tbl_angle[0];
        else if (q > tbl_angle[n - 1])
            q = tbl_angle[n - 1];
        for (int i = 0; i + 1 < n; i++) begin
            a0 = tbl_angle[i];
            a1 = tbl_angle[i + 1];
            if (q >= a0 && q <= a1) begin
                r.lift   = interp_coeff(q, a0, a1, tbl_lift[i], tbl_lift[i + 1]);
                r.drag   = interp_coeff(q, a0, a1, tbl_drag[i], tbl_drag[i + 1]);
                r.moment = interp_coeff(q, a0, a1, tbl_moment[i], tbl_moment[i + 1]);
                r.found  = 1'b1;
                return r;
            end
        end
        return r;
    endfunction

    function automatic polar_result_t lift_slope_estimate();
        polar_result_t r;
        int n, centre, p, used;
        longint da, snum, sden, mag_n, mag_d, qm, s;
        r = '{default: '0};
        n = active_entries();
        centre = 0;
        used = 0;
        snum = 0;
        sden = 0;
        s = TWO_PI_SLOPE;
        if (n >= 3) begin
            // window centers on the first zero crossing, else on segment zero
            for (int i = 0; i + 1 < n; i++) begin
                if (tbl_angle[i] <= 0 && tbl_angle[i + 1] >= 0) begin
                    centre = i;
                    break;
                end
            end
            for (int k = -2; k <= 2; k++) begin
                p = centre + k;
                if (p >= 0 && p + 1 < n) begin
                    da = longint'(tbl_angle[p + 1]) - longint'(tbl_angle[p]);
                    if (da != 0) begin
                        snum += longint'(tbl_lift[p + 1]) - longint'(tbl_lift[p]);
                        sden += da;
                        used++;
                    end
                end
            end
            if (used != 0 && sden != 0) begin
                mag_n = (snum < 0) ? -snum : snum;
                mag_d = (sden < 0) ? -sden : sden;
                qm = (mag_n * DEG128_TO_RAD_Q12 * INV_PI_Q30 + (mag_d << 30) / 2)
                     / (mag_d << 30);
                if (qm > SLOPE_HI + 1)
                    qm = SLOPE_HI + 1;
                s = ((snum < 0) != (sden < 0)) ? -qm : qm;
                if (s > SLOPE_HI)
                    s = SLOPE_HI;
            end
        end
        r.slope = 20'(s);
        return r;
    endfunction

    function automatic void track_polar_item(polar_item_t it);
        case (it.op)
            afpi_pkg::OP_WRITE: begin
                tbl_angle[it.index]  = it.angle;
                tbl_lift[it.index]   = it.lift;
                tbl_drag[it.index]   = it.drag;
                tbl_moment[it.index] = it.moment;
            end
            afpi_pkg::OP_SAMPLE: results_due.push_back(sample_polar(it.query));
            afpi_pkg::OP_SLOPE:  results_due.push_back(lift_slope_estimate());
            default: ;
        endcase
    endfunction

    // ---------------------------------------------------------------
    // Result checking
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin : result_check
        polar_result_t want, got;
        if (i_rst_n && o_valid && !i_stall) begin
            got = '{o_lift_coeff, o_drag_coeff, o_moment_coeff, o_found, o_slope_per_rad};
            if (results_due.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("unexpected result: lift %0d drag %0d moment %0d found %0d slope %0d",
                             got.lift, got.drag, got.moment, got.found, got.slope);
            end else begin
                want = results_due.pop_front();
                if (got.lift !== want.lift || got.drag !== want.drag ||
                    got.moment !== want.moment || got.found !== want.found ||
                    got.slope !== want.slope) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display({"result mismatch (exp/got): lift %0d/%0d drag %0d/%0d",
                                  " moment %0d/%0d found %0d/%0d slope %0d/%0d"},
                                 want.lift, got.lift, want.drag, got.drag,
                                 want.moment, got.moment, want.found, got.found,
                                 want.slope, got.slope);
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Idle gaps, result-side stall
    // ---------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 2);
        if (r < 95)
            return $urandom_range(3, 8);
        return $urandom_range(20, 60);
    endfunction

    initial begin : result_stall_drive
        int hold_left;
        hold_left = 0;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left == 0 && long_hold_req != 0) begin
                hold_left = long_hold_req;
                long_hold_req = 0;
            end else if (hold_left == 0 && rx_idling && $urandom_range(0, 4) == 0) begin
                hold_left = pick_gap();
            end
            if (hold_left != 0) begin
                i_stall = 1'b1;
                hold_left--;
            end else begin
                i_stall = 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // Item and config drivers
    // ---------------------------------------------------------------
    task automatic pause_sender(int cycles);
        @(negedge i_clk);
        i_valid = 1'b0;
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    task automatic send_item(polar_item_t it);
        @(negedge i_clk);
        i_valid        = 1'b1;
        i_operation    = it.op;
        i_entry_index  = it.index;
        i_entry_angle  = it.angle;
        i_entry_lift   = it.lift;
        i_entry_drag   = it.drag;
        i_entry_moment = it.moment;
        i_query_angle  = it.query;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        track_polar_item(it);
        if (it.op != OP_RESERVED)
            items_sent++;
        if (tx_idling && $urandom_range(0, 3) == 0)
            pause_sender(pick_gap());
    endtask

    task automatic wait_for_results();
        pause_sender(1);
        while (results_due.size() != 0) @(posedge i_clk);
    endtask

    // only while idle: drain, let a trailing write settle, then write
    task automatic set_entry_count(int value);
        wait_for_results();
        repeat (CFG_SETTLE) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data  = afpi_pkg::CNT_W'(value);
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        tbl_count = afpi_pkg::CNT_W'(value);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // all fields random; callers override what matters
    function automatic polar_item_t random_item(logic [afpi_pkg::OP_W-1:0] op);
        polar_item_t it;
        it.op     = op;
        it.index  = afpi_pkg::IDX_W'($urandom);
        it.angle  = 16'($urandom);
        it.lift   = 16'($urandom);
        it.drag   = 16'($urandom);
        it.moment = 16'($urandom);
        it.query  = 16'($urandom);
        return it;
    endfunction

    task automatic write_entry(int idx, int ang, int lift, int drag, int moment);
        polar_item_t it;
        it        = random_item(afpi_pkg::OP_WRITE);
        it.index  = afpi_pkg::IDX_W'(idx);
        it.angle  = 16'(ang);
        it.lift   = 16'(lift);
        it.drag   = 16'(drag);
        it.moment = 16'(moment);
        send_item(it);
    endtask

    task automatic sample_at(int q);
        polar_item_t it;
        it       = random_item(afpi_pkg::OP_SAMPLE);
        it.query = 16'(q);
        send_item(it);
    endtask

    task automatic ask_slope();
        send_item(random_item(afpi_pkg::OP_SLOPE));
    endtask

    // query mostly within 64 of the table span, sometimes on an entry or anywhere
    function automatic logic signed [15:0] pick_query();
        int n, lo, hi, t, r;
        n = active_entries();
        r = $urandom_range(0, 9);
        if (n == 0 || r < 2)
            return 16'($urandom);
        if (r < 4)
            return tbl_angle[$urandom_range(0, n - 1)];
        lo = tbl_angle[0];
        hi = tbl_angle[n - 1];
        if (lo > hi) begin
            t  = lo;
            lo = hi;
            hi = t;
        end
        lo = (lo - 64 < -32768) ? -32768 : lo - 64;
        hi = (hi + 64 > 32767) ? 32767 : hi + 64;
        return 16'(lo + int'($urandom_range(0, hi - lo)));
    endfunction

    // writes entries 0..n-1; ramp and wild tables are sorted by angle
    task automatic load_table(int n, table_shape_t shape);
        int step_max, ang, lift, lift_step;
        step_max = 0;
        if (n > 1) begin
            if (shape == SHAPE_RAMP || $urandom_range(0, 2) != 0)
                step_max = $urandom_range(1, 400);
            else
                step_max = 65535 / (n - 1);
            if (step_max > 65535 / (n - 1))
                step_max = 65535 / (n - 1);
        end
        if (shape == SHAPE_RAMP)
            ang = -int'($urandom_range(0, step_max * (n > 0 ? n - 1 : 0)));
        else
            ang = -32768 + int'($urandom_range(0, 65535 - step_max * (n > 0 ? n - 1 : 0)));
        lift      = int'($urandom_range(0, 4000)) - 3000;
        lift_step = $urandom_range(0, 300);
        for (int i = 0; i < n; i++) begin
            case (shape)
                SHAPE_RAMP:
                    write_entry(i, ang, lift, $urandom_range(0, 2000),
                                int'($urandom_range(0, 1000)) - 500);
                SHAPE_WILD:
                    write_entry(i, ang, shortint'($urandom), shortint'($urandom),
                                shortint'($urandom));
                default:
                    write_entry(i, shortint'($urandom), shortint'($urandom),
                                shortint'($urandom), shortint'($urandom));
            endcase
            // an occasional zero step gives a zero-width segment
            if ($urandom_range(0, 7) != 0)
                ang += $urandom_range(0, step_max);
            lift += lift_step + int'($urandom_range(0, 200)) - 100;
        end
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    // every entry gets written before anything reads the table
    task automatic test_table_fill();
        load_table(TABLE_DEPTH, SHAPE_WILD);
    endtask

    // table spanning the full angle range, a zero-width segment, rounding ties, clamping
    task automatic test_segment_edges();
        set_entry_count(4);
        write_entry(0, -32768, -32768, 32767, 0);
        write_entry(1, 0, 0, -32768, 32767);
        write_entry(2, 0, 4096, 100, -32768);
        write_entry(3, 32767, 32767, 0, -1);
        sample_at(-32768);
        sample_at(32767);
        sample_at(0);
        sample_at(-16384);
        sample_at(1);
        ask_slope();
        send_item(random_item(OP_RESERVED));
    endtask

    // first angle above the last: a low query clamps to the first and finds no bracket, a high one clamps to the last
    task automatic test_inverted_span();
        write_entry(0, 1000, 2048, -2048, 512);
        set_entry_count(3);
        sample_at(2000);
        sample_at(-5000);
        ask_slope();
    endtask

    task automatic test_slope_fallbacks();
        // spans cancel out, and no zero crossing
        write_entry(0, 5, 100, 200, 300);
        write_entry(1, 10, -400, 500, -600);
        write_entry(2, 5, 700, -800, 900);
        ask_slope();
        sample_at(7);
        // every segment zero width
        write_entry(1, 5, 1000, 1100, 1200);
        ask_slope();
        // too few entries
        set_entry_count(2);
        ask_slope();
        set_entry_count(1);
        sample_at(0);
        set_entry_count(0);
        sample_at(0);
    endtask

    // receiver holds off long while the sender keeps offering items
    task automatic test_backpressure();
        tx_idling = 1'b0;
        rx_idling = 1'b0;
        load_table(16, SHAPE_RAMP);
        set_entry_count(16);
        long_hold_req = LONG_HOLD;
        repeat (10) begin
            if ($urandom_range(0, 3) == 0)
                ask_slope();
            else
                sample_at(pick_query());
        end
        // sender waits for every result before going on
        wait_for_results();
        tx_idling = 1'b1;
        rx_idling = 1'b1;
        repeat (6) sample_at(pick_query());
    endtask

    task automatic test_random_phases();
        int cnt, pick;
        polar_item_t it;
        while (items_sent < ITEM_TARGET) begin
            tx_idling = $urandom_range(0, 3) != 0;
            rx_idling = $urandom_range(0, 3) != 0;
            // mostly small tables, a few full or over-full counts
            pick = $urandom_range(0, 19);
            if (pick == 0)
                cnt = $urandom_range(TABLE_DEPTH + 1, 127);
            else if (pick == 1)
                cnt = TABLE_DEPTH;
            else if (pick == 2)
                cnt = $urandom_range(0, 2);
            else if (pick < 6)
                cnt = $urandom_range(17, TABLE_DEPTH - 1);
            else
                cnt = $urandom_range(3, 16);
            if ($urandom_range(0, 4) != 0) begin
                pick = $urandom_range(0, 9);
                load_table(cnt > TABLE_DEPTH ? TABLE_DEPTH : cnt,
                           pick < 5 ? SHAPE_RAMP : (pick < 8 ? SHAPE_WILD : SHAPE_NOISE));
            end
            set_entry_count(cnt);
            repeat ($urandom_range(20, 50)) begin
                pick = $urandom_range(0, 99);
                if (pick < 60) begin
                    it = random_item(afpi_pkg::OP_SAMPLE);
                    it.query = pick_query();
                end else if (pick < 80) begin
                    it = random_item(afpi_pkg::OP_SLOPE);
                end else if (pick < 92) begin
                    it = random_item(afpi_pkg::OP_WRITE);
                end else begin
                    it = random_item(OP_RESERVED);
                end
                send_item(it);
            end
        end
    endtask

    // ---------------------------------------------------------------
    // Run control
    // ---------------------------------------------------------------
    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("tb: failure");
        $finish;
    end

    initial begin : stimulus
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_operation    = '0;
        i_entry_index  = '0;
        i_entry_angle  = '0;
        i_entry_lift   = '0;
        i_entry_drag   = '0;
        i_entry_moment = '0;
        i_query_angle  = '0;
        i_cfg_valid    = 1'b0;
        i_cfg_data     = '0;
        tbl_count      = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_table_fill();
        test_segment_edges();
        test_inverted_span();
        test_slope_fallbacks();
        test_backpressure();
        test_random_phases();

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && results_due.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
